### rtl/core/ssdf_pkg.sv
// Package for the seven-segment decimal frame builder.
// Holds bus command codes, divide constants, the frame type and the segment decoder.
// No dependencies.
package ssdf_pkg;

    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY = 8'h80;

    localparam int NUM_W   = 14;
    localparam int DIGITS  = 4;
    localparam logic [2:0] MAX_COUNT = 3'd4;

    // reciprocal constants, exact for any 14-bit value
    localparam logic [14:0] RECIP_1000 = 15'd16778;  // 2^24 / 1000, rounded up
    localparam logic [13:0] RECIP_100  = 14'd10486;  // 2^20 / 100, rounded up
    localparam logic [15:0] RECIP_10   = 16'd52429;  // 2^19 / 10, rounded up

    localparam logic [7:0] SEG_ZERO  = 8'h3F;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    typedef logic [DIGITS-1:0][7:0] t_segs;

    typedef struct packed {
        t_segs      segs;   // segs[0] is the thousands digit
        logic [2:0] count;
        logic [1:0] pos;
    } t_frame;

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        unique case (d)
            4'h0:    p = 8'h3F;
            4'h1:    p = 8'h06;
            4'h2:    p = 8'h5B;
            4'h3:    p = 8'h4F;
            4'h4:    p = 8'h66;
            4'h5:    p = 8'h6D;
            4'h6:    p = 8'h7D;
            4'h7:    p = 8'h07;
            4'h8:    p = 8'h7F;
            4'h9:    p = 8'h6F;
            4'hA:    p = 8'h77;
            4'hB:    p = 8'h7C;
            4'hC:    p = 8'h39;
            4'hD:    p = 8'h5E;
            4'hE:    p = 8'h79;
            default: p = 8'h71;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/ssdf_digit_encode.sv
// Decimal split and segment encoding with leading-zero blanking.
// Uses ssdf_pkg for the reciprocal constants and the segment decoder.
module ssdf_digit_encode
    import ssdf_pkg::*;
(
    input  logic [NUM_W-1:0] i_number,
    input  logic             i_show_zeros,
    output t_segs            o_segs
);

    logic [28:0] w_p1000;
    logic [27:0] w_p100;
    logic [29:0] w_p10;
    logic [4:0]  w_q1000;
    logic [7:0]  w_q100;
    logic [10:0] w_q10;
    logic [7:0]  w_d2_full;
    logic [10:0] w_d1_full;
    logic [13:0] w_d0_full;
    logic [3:0]  w_d2;
    logic [3:0]  w_d1;
    logic [3:0]  w_d0;
    logic        w_nz3;
    logic        w_nz2;
    logic        w_nz1;

    assign w_p1000 = 29'(i_number) * 29'(RECIP_1000);
    assign w_p100  = 28'(i_number) * 28'(RECIP_100);
    assign w_p10   = 30'(i_number) * 30'(RECIP_10);

    assign w_q1000 = w_p1000[28:24];
    assign w_q100  = w_p100[27:20];
    assign w_q10   = w_p10[29:19];

    assign w_d2_full = w_q100 - 8'(8'({3'b000, w_q1000}) * 8'd10);
    assign w_d1_full = w_q10 - 11'(11'({3'b000, w_q100}) * 11'd10);
    assign w_d0_full = i_number - 14'(14'({3'b000, w_q10}) * 14'd10);

    assign w_d2 = w_d2_full[3:0];
    assign w_d1 = w_d1_full[3:0];
    assign w_d0 = w_d0_full[3:0];

    // thousands of 16 wraps to pattern 0 but still counts as nonzero
    assign w_nz3 = (w_q1000 != 5'd0);
    assign w_nz2 = w_nz3 || (w_d2 != 4'd0);
    assign w_nz1 = w_nz2 || (w_d1 != 4'd0);

    always_comb begin
        o_segs[0] = w_nz3 ? seg_pattern(w_q1000[3:0])
                          : (i_show_zeros ? SEG_ZERO : SEG_BLANK);
        o_segs[1] = (w_nz2 || i_show_zeros) ? seg_pattern(w_d2) : SEG_BLANK;
        o_segs[2] = (w_nz1 || i_show_zeros) ? seg_pattern(w_d1) : SEG_BLANK;
        o_segs[3] = seg_pattern(w_d0);
    end

endmodule

### rtl/core/ssdf_byte_sequencer.sv
// Frame register and byte sequencer driving the registered output channel.
// Uses ssdf_pkg for command codes and the frame type.
module ssdf_byte_sequencer
    import ssdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_frame_valid,
    input  t_frame     i_frame,
    output logic       o_frame_ready,
    input  logic [7:0] i_brightness,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_bus_byte,
    output logic       o_frame_start,
    output logic       o_frame_stop,
    output logic       o_last_byte
);

    t_frame     r_frame;
    logic       r_f_vld;
    logic [2:0] r_idx;
    logic       r_o_vld;
    logic [7:0] r_byte;
    logic       r_start;
    logic       r_stop;
    logic       r_last;

    logic       w_load;
    logic       w_is_last;
    logic [2:0] w_last_idx;
    logic [2:0] w_seg_sel;
    logic [7:0] n_byte;
    logic       n_start;
    logic       n_stop;

    assign w_load        = r_f_vld && (!r_o_vld || i_ready);
    assign w_last_idx    = r_frame.count + 3'd2;
    assign w_is_last     = (r_idx == w_last_idx);
    assign o_frame_ready = !r_f_vld || (w_load && w_is_last);
    assign w_seg_sel     = r_idx + 3'd2 - r_frame.count;

    always_comb begin
        if (r_idx == 3'd0) begin
            n_byte  = CMD_DATA;
            n_start = 1'b1;
            n_stop  = 1'b1;
        end else if (r_idx == 3'd1) begin
            n_byte  = CMD_ADDR | {6'd0, r_frame.pos};
            n_start = 1'b1;
            n_stop  = (r_frame.count == 3'd0);
        end else if (w_is_last) begin
            n_byte  = CMD_DISPLAY | {4'd0, i_brightness[3:0]};
            n_start = 1'b1;
            n_stop  = 1'b1;
        end else begin
            n_byte  = r_frame.segs[w_seg_sel[1:0]];
            n_start = 1'b0;
            n_stop  = (w_seg_sel[1:0] == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_idx   <= 3'd0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_frame_ready && i_frame_valid) begin
                r_f_vld <= 1'b1;
                r_idx   <= 3'd0;
            end else if (w_load) begin
                r_idx <= r_idx + 3'd1;
                if (w_is_last) begin
                    r_f_vld <= 1'b0;
                end
            end
            if (w_load) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_ready && i_frame_valid) begin
            r_frame <= i_frame;
        end
        if (w_load) begin
            r_byte  <= n_byte;
            r_start <= n_start;
            r_stop  <= n_stop;
            r_last  <= w_is_last;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_bus_byte    = r_byte;
    assign o_frame_start = r_start;
    assign o_frame_stop  = r_stop;
    assign o_last_byte   = r_last;

endmodule

### rtl/core/seven_segment_decimal_frame_builder_unit.sv
// Top level of the seven-segment decimal frame builder.
// Depends on ssdf_pkg, ssdf_digit_encode and ssdf_byte_sequencer.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------------
//  input   | i_valid / o_ready         | i_number, i_show_leading_zeros,
//          |                           | i_digit_count, i_start_position
//  result  | o_valid / i_ready         | o_bus_byte, o_frame_start, o_frame_stop,
//          |                           | o_last_byte
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_brightness
//
// Each request yields digit_count + 3 bytes (digit count above 4 counts as 4), one per
// cycle while the result side is ready; the byte sequencer sets the rate.
// The first byte passes the input stage, the frame register and the output register.
// The next request is taken while the current one is still being sent.
// Reset is synchronous; it empties all stages and sets brightness to 0.
// A stall on the result side holds the output byte and backs up into the input stage.
module seven_segment_decimal_frame_builder_unit
    import ssdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [NUM_W-1:0] i_number,
    input  logic             i_show_leading_zeros,
    input  logic [2:0]       i_digit_count,
    input  logic [1:0]       i_start_position,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_bus_byte,
    output logic             o_frame_start,
    output logic             o_frame_stop,
    output logic             o_last_byte,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_brightness
);

    logic             r_a_vld;
    logic [NUM_W-1:0] r_a_number;
    logic             r_a_zeros;
    logic [2:0]       r_a_count;
    logic [1:0]       r_a_pos;
    logic [7:0]       r_brightness;

    logic             w_frame_ready;
    t_segs            w_segs;
    t_frame           w_frame;

    assign o_ready     = !r_a_vld || w_frame_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld      <= 1'b0;
            r_brightness <= 8'd0;
        end else begin
            if (o_ready) begin
                r_a_vld <= i_valid;
            end
            if (i_cfg_valid) begin
                r_brightness <= i_cfg_brightness;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_number <= i_number;
            r_a_zeros  <= i_show_leading_zeros;
            r_a_count  <= (i_digit_count > MAX_COUNT) ? MAX_COUNT : i_digit_count;
            r_a_pos    <= i_start_position;
        end
    end

    ssdf_digit_encode u_encode (
        .i_number     (r_a_number),
        .i_show_zeros (r_a_zeros),
        .o_segs       (w_segs)
    );

    always_comb begin
        w_frame.segs  = w_segs;
        w_frame.count = r_a_count;
        w_frame.pos   = r_a_pos;
    end

    ssdf_byte_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (r_a_vld),
        .i_frame       (w_frame),
        .o_frame_ready (w_frame_ready),
        .i_brightness  (r_brightness),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bus_byte    (o_bus_byte),
        .o_frame_start (o_frame_start),
        .o_frame_stop  (o_frame_stop),
        .o_last_byte   (o_last_byte)
    );

    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !w_frame_ready |=> r_a_vld && $stable(r_a_number))
        else $error("input stage lost a waiting request");

    a_seq_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_byte) ##1 o_valid |-> o_bus_byte == CMD_DATA)
        else $error("sequence did not restart with data command");

    a_addr_then_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_frame_start && !o_frame_stop
        |=> o_valid && !o_frame_start)
        else $error("segment byte missing after address command");

    a_last_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_byte |-> o_frame_start && o_frame_stop
            && o_bus_byte[7:4] == CMD_DISPLAY[7:4])
        else $error("final byte is not a framed display command");

endmodule

### tb/seven_segment_decimal_frame_builder_unit_tb.sv
// Testbench for seven_segment_decimal_frame_builder_unit: drives number requests and
// brightness writes, predicts every bus byte with frame marks, checks them in order.
// Depends on ssdf_pkg and the block's RTL.
module seven_segment_decimal_frame_builder_unit_tb;
    import ssdf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 160;
    localparam int DRAIN_CYCLES    = 16;

    // digit glyphs, XGFEDCBA, index 15 first
    localparam logic [15:0][7:0] DIGIT_GLYPH = {
        8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // one bus byte as seen on the result channel
    typedef struct packed {
        logic       frame_start;
        logic       frame_stop;
        logic       last_byte;
        logic [7:0] bus_byte;
    } t_bus_rec;

    // typed bytes read {start,stop,last} in the top hex digit; n_typed 0 means predicted
    typedef struct packed {
        logic [13:0]      number;
        logic             zeros;
        logic [2:0]       count;
        logic [1:0]       pos;
        logic [2:0]       n_typed;
        logic [6:0][10:0] typed;
    } t_dir_row;

    localparam int N_DIRECTED = 20;

    t_dir_row directed_rows [N_DIRECTED] = '{
        {14'd0,     1'b0, 3'd4, 2'd0, 3'd7, 11'h640, 11'h4C0, 11'h000, 11'h000,
                                            11'h000, 11'h23F, 11'h780},
        {14'd0,     1'b1, 3'd4, 2'd3, 3'd7, 11'h640, 11'h4C3, 11'h03F, 11'h03F,
                                            11'h03F, 11'h23F, 11'h780},
        {14'd9999,  1'b0, 3'd4, 2'd0, 3'd7, 11'h640, 11'h4C0, 11'h06F, 11'h06F,
                                            11'h06F, 11'h26F, 11'h780},
        {14'd16383, 1'b0, 3'd4, 2'd0, 3'd7, 11'h640, 11'h4C0, 11'h03F, 11'h04F,
                                            11'h07F, 11'h24F, 11'h780},
        {14'd5,     1'b0, 3'd0, 2'd2, 3'd3, 11'h640, 11'h6C2, 11'h780, 11'h000,
                                            11'h000, 11'h000, 11'h000},
        {14'd1234,  1'b0, 3'd7, 2'd1, 3'd7, 11'h640, 11'h4C1, 11'h006, 11'h05B,
                                            11'h04F, 11'h266, 11'h780},
        {14'd10000, 1'b0, 3'd4, 2'd0, 3'd0, 77'd0},
        {14'd11111, 1'b1, 3'd4, 2'd1, 3'd0, 77'd0},
        {14'd12345, 1'b0, 3'd4, 2'd2, 3'd0, 77'd0},
        {14'd13579, 1'b0, 3'd4, 2'd3, 3'd0, 77'd0},
        {14'd14000, 1'b0, 3'd4, 2'd0, 3'd0, 77'd0},
        {14'd15999, 1'b0, 3'd4, 2'd0, 3'd0, 77'd0},
        {14'd16000, 1'b0, 3'd4, 2'd0, 3'd0, 77'd0},
        {14'd7,     1'b0, 3'd1, 2'd1, 3'd0, 77'd0},
        {14'd42,    1'b0, 3'd2, 2'd2, 3'd0, 77'd0},
        {14'd305,   1'b0, 3'd3, 2'd3, 3'd0, 77'd0},
        {14'd1005,  1'b0, 3'd5, 2'd0, 3'd0, 77'd0},
        {14'd50,    1'b1, 3'd6, 2'd1, 3'd0, 77'd0},
        {14'd8,     1'b0, 3'd4, 2'd2, 3'd0, 77'd0},
        {14'd8190,  1'b1, 3'd4, 2'd0, 3'd0, 77'd0}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [NUM_W-1:0] i_number;
    logic             i_show_leading_zeros;
    logic [2:0]       i_digit_count;
    logic [1:0]       i_start_position;
    logic             o_valid;
    logic             i_ready;
    logic [7:0]       o_bus_byte;
    logic             o_frame_start;
    logic             o_frame_stop;
    logic             o_last_byte;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_brightness;

    t_bus_rec   pending_bytes [$];
    t_bus_rec   head_rec;
    logic [7:0] brightness_shadow;
    int         mismatch_count;
    int         idle_cycles;
    int         stalls_asked;
    int         stalls_taken;
    logic       no_idle;

    seven_segment_decimal_frame_builder_unit u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_number             (i_number),
        .i_show_leading_zeros (i_show_leading_zeros),
        .i_digit_count        (i_digit_count),
        .i_start_position     (i_start_position),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_bus_byte           (o_bus_byte),
        .o_frame_start        (o_frame_start),
        .o_frame_stop         (o_frame_stop),
        .o_last_byte          (o_last_byte),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_brightness     (i_cfg_brightness)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int sender_gap();
        if (no_idle || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    task automatic predict_frame(input logic [13:0] number, input logic zeros,
                                 input logic [2:0] count, input logic [1:0] pos);
        int unsigned     rest;
        int unsigned     quot;
        int unsigned     place;
        int              n_seg;
        logic [3:0][7:0] glyphs;
        logic            leading;
        rest    = number;
        place   = 1000;
        leading = 1'b1;
        n_seg   = (count > 3'd4) ? 4 : int'(count);
        for (int k = 0; k < 4; k++) begin
            quot = rest / place;
            if (quot == 0) begin
                glyphs[k] = (zeros || !leading || k == 3) ? DIGIT_GLYPH[0] : 8'h00;
            end else begin
                glyphs[k] = DIGIT_GLYPH[quot[3:0]];
                rest      = rest - quot * place;
                leading   = 1'b0;
            end
            place = place / 10;
        end
        pending_bytes.push_back({1'b1, 1'b1, 1'b0, CMD_DATA});
        pending_bytes.push_back({1'b1, n_seg == 0, 1'b0, 8'(CMD_ADDR + pos)});
        for (int k = 4 - n_seg; k < 4; k++)
            pending_bytes.push_back({1'b0, k == 3, 1'b0, glyphs[k]});
        pending_bytes.push_back({1'b1, 1'b1, 1'b1,
                                 8'(CMD_DISPLAY + brightness_shadow[3:0])});
    endtask

    task automatic offer_request(input logic [13:0] number, input logic zeros,
                                 input logic [2:0] count, input logic [1:0] pos,
                                 input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_number             <= number;
        i_show_leading_zeros <= zeros;
        i_digit_count        <= count;
        i_start_position     <= pos;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic offer_random_request(input int gap);
        logic [13:0] number;
        logic        zeros;
        logic [2:0]  count;
        logic [1:0]  pos;
        case ($urandom_range(0, 3))
            0:       number = 14'($urandom_range(0, 16383));
            1:       number = 14'($urandom_range(0, 99));
            2:       number = 14'($urandom_range(100, 9999));
            default: number = 14'($urandom_range(10000, 16383));
        endcase
        zeros = 1'($urandom_range(0, 1));
        count = 3'($urandom_range(0, 7));
        pos   = 2'($urandom_range(0, 3));
        offer_request(number, zeros, count, pos, gap);
        predict_frame(number, zeros, count, pos);
    endtask

    // only while idle: all bytes drained, plus a margin
    task automatic write_brightness(input logic [7:0] value);
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_brightness <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid       <= 1'b0;
        brightness_shadow  = value;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                mismatch_count++;
                $display("%0t: bus_byte expected none actual %h", $time, o_bus_byte);
            end else begin
                head_rec = pending_bytes.pop_front();
                compare_field("bus_byte", head_rec.bus_byte, o_bus_byte);
                compare_field("frame_start", 8'(head_rec.frame_start), 8'(o_frame_start));
                compare_field("frame_stop", 8'(head_rec.frame_stop), 8'(o_frame_stop));
                compare_field("last_byte", 8'(head_rec.last_byte), 8'(o_last_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random back-pressure, plus a long hold-off when asked
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_taken != stalls_asked) begin
                stalls_taken++;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat (idle_len() - 1) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_dir_row row;
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_number             = '0;
        i_show_leading_zeros = 1'b0;
        i_digit_count        = '0;
        i_start_position     = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_brightness     = '0;
        brightness_shadow    = '0;
        mismatch_count       = 0;
        idle_cycles          = 0;
        stalls_asked         = 0;
        stalls_taken         = 0;
        no_idle              = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_request(row.number, row.zeros, row.count, row.pos, sender_gap());
            if (row.n_typed == 0)
                predict_frame(row.number, row.zeros, row.count, row.pos);
            else
                for (int k = 0; k < int'(row.n_typed); k++)
                    pending_bytes.push_back(row.typed[6 - k]);
        end

        write_brightness(8'hFF);
        repeat (50) offer_random_request(sender_gap());

        // receiver holds off while requests keep coming
        write_brightness(8'($urandom_range(1, 254)));
        stalls_asked++;
        repeat (25) offer_random_request(0);
        repeat (25) offer_random_request(sender_gap());

        write_brightness(8'h00);
        no_idle = 1'b1;
        repeat (50) offer_random_request(0);
        no_idle = 1'b0;

        write_brightness(8'($urandom_range(0, 255)));
        repeat (55) offer_random_request(sender_gap());

        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ssdf_pkg.sv
rtl/core/ssdf_digit_encode.sv
rtl/core/ssdf_byte_sequencer.sv
rtl/core/seven_segment_decimal_frame_builder_unit.sv
tb/seven_segment_decimal_frame_builder_unit_tb.sv
